>>> hw/rtl/salsa20_stream_decrypt_unit_assert.svh
// Assertion macros for the Salsa20 stream decrypt unit.
// Used by the top level; expects clk and rst in scope where they are used.
`ifndef SALSA20_STREAM_DECRYPT_UNIT_ASSERT_SVH
`define SALSA20_STREAM_DECRYPT_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define S20SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define S20SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/s20sd_pkg.sv
// Shared types, constants and helper functions for the Salsa20 stream decrypt unit.
// No dependencies; imported by the controller, the datapath and the top level.
package s20sd_pkg;

  localparam int WORD_W        = 32;
  localparam int NUM_WORDS     = 16;
  localparam int BYTE_W        = 8;
  localparam int POS_W         = 6;
  localparam int CTR_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int DROUND_W      = 4;
  localparam int PHASE_W       = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_KEY_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_VALUE     = 3'd5;

  // "expand 16-byte k" and "expand 32-byte k" as little-endian words.
  localparam logic [WORD_W-1:0] SIGMA16 [4] = '{
    32'h61707865, 32'h3120646e, 32'h79622d36, 32'h6b206574
  };
  localparam logic [WORD_W-1:0] SIGMA32 [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  // Quarter-round word groups (a, b, c, d): column half first, then row half.
  localparam logic [3:0] QR_INDEX [2][4][4] = '{
    '{ '{4'd0,  4'd4,  4'd8,  4'd12},
       '{4'd5,  4'd9,  4'd13, 4'd1 },
       '{4'd10, 4'd14, 4'd2,  4'd6 },
       '{4'd15, 4'd3,  4'd7,  4'd11} },
    '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
       '{4'd5,  4'd6,  4'd7,  4'd4 },
       '{4'd10, 4'd11, 4'd8,  4'd9 },
       '{4'd15, 4'd12, 4'd13, 4'd14} }
  };

  // Configuration register file contents.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] key_first_low;
    logic [CFG_DATA_W-1:0] key_first_high;
    logic [CFG_DATA_W-1:0] key_second_low;
    logic [CFG_DATA_W-1:0] key_second_high;
    logic                  long_key_mode;
    logic [CFG_DATA_W-1:0] nonce_value;
  } s20sd_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                capture;    // Hold the request that starts a new block.
    logic                load;       // Load the initial state words.
    logic                round_en;   // Run one quarter-round step on all four groups.
    logic [PHASE_W-1:0]  phase;      // Bit 2 selects the row half, bits 1:0 the step.
    logic [DROUND_W-1:0] dround;     // Double-round count.
    logic                feed;       // Add the initial state back in.
    logic                emit;       // Write a result into the output register.
    logic                emit_held;  // The result comes from the held request.
  } s20sd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_zero;  // Next byte starts a new keystream block.
  } s20sd_status_t;

  // Rotate left by the amount of quarter-round step 0..3 (7, 9, 13, 18).
  function automatic logic [WORD_W-1:0] rotl_step(input logic [WORD_W-1:0] v,
                                                  input logic [1:0] step);
    logic [WORD_W-1:0] r;
    unique case (step)
      2'd0: r = {v[24:0], v[31:25]};
      2'd1: r = {v[22:0], v[31:23]};
      2'd2: r = {v[18:0], v[31:19]};
      2'd3: r = {v[13:0], v[31:14]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/salsa20_stream_decrypt_unit.sv
// Salsa20/20 stream decrypt unit, one byte per request; uses s20sd_pkg, s20sd_ctrl, s20sd_core.
// A byte at block positions 1..63 goes into the output register as it is taken, so its result
// shows in the next cycle. A byte at position zero first builds a keystream block: a load
// step, the quarter-round steps (four groups in parallel) and a feed-forward step; then an
// emit state writes its result once the output register is free. No byte is taken meanwhile.
// Synchronous active-high reset clears configuration, block counter, position and valids.
module salsa20_stream_decrypt_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] cipher_byte
  input  logic                                 s_tlast,   // final_byte
  // Output stream.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,   // [7:0] plain_byte
  output logic                                 m_tlast,   // final_out
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [s20sd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [s20sd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import s20sd_pkg::*;

  `include "salsa20_stream_decrypt_unit_assert.svh"

  s20sd_cfg_t    cfg;
  s20sd_cmd_t    cmd;
  s20sd_status_t status;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_FIRST_LOW:   cfg.key_first_low   <= cfg_data;
        REG_KEY_FIRST_HIGH:  cfg.key_first_high  <= cfg_data;
        REG_KEY_SECOND_LOW:  cfg.key_second_low  <= cfg_data;
        REG_KEY_SECOND_HIGH: cfg.key_second_high <= cfg_data;
        REG_LONG_KEY_MODE:   cfg.long_key_mode   <= cfg_data[0];
        REG_NONCE_VALUE:     cfg.nonce_value     <= cfg_data;
        default: ;
      endcase
    end
  end

  s20sd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  s20sd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_byte   (s_tdata),
    .in_final  (s_tlast),
    .out_byte  (m_tdata),
    .out_final (m_tlast),
    .status    (status)
  );

  // A result is only written into a free output register.
  `S20SD_ASSERT_NOW(a_emit_slot_free, cmd.emit, !m_tvalid || m_tready, "result overwrote pending output")

  // A byte inside a block produces its result on the next cycle.
  `S20SD_ASSERT_NEXT(a_mid_block_result, s_tvalid && s_tready && !status.pos_zero, m_tvalid, "mid-block byte gave no result")

  // A final byte inside a block rewinds the position as its result is written.
  `S20SD_ASSERT_NEXT(a_final_rewinds, s_tvalid && s_tready && s_tlast && !status.pos_zero, status.pos_zero, "final byte did not rewind position")

  // The round sequencer never runs past the last double round.
  `S20SD_ASSERT_NOW(a_round_bound, cmd.round_en, cmd.dround < DROUND_W'(DOUBLE_ROUNDS), "double-round count out of range")

endmodule

>>> hw/rtl/s20sd_ctrl.sv
// Controller state machine of the Salsa20 stream decrypt unit.
// Depends on s20sd_pkg; drives the datapath with s20sd_cmd_t commands.
module s20sd_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  input  s20sd_pkg::s20sd_status_t status,
  output s20sd_pkg::s20sd_cmd_t    cmd
);
  import s20sd_pkg::*;

  typedef enum logic [4:0] {
    ST_STREAM = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_FEED   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [PHASE_W-1:0]  phase, phase_next;
  logic [DROUND_W-1:0] dround, dround_next;
  logic                out_valid, out_valid_next;
  logic                slot_free;
  logic                accept;

  // Output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == ST_STREAM) && slot_free;
  assign accept    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;

  // Commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.capture   = accept && status.pos_zero;
    cmd.load      = (state == ST_LOAD);
    cmd.round_en  = (state == ST_ROUND);
    cmd.phase     = phase;
    cmd.dround    = dround;
    cmd.feed      = (state == ST_FEED);
    cmd.emit_held = (state == ST_EMIT);
    cmd.emit      = (accept && !status.pos_zero) || ((state == ST_EMIT) && slot_free);
  end

  // Next-state logic: one quarter-round step per cycle, eight per double round.
  always_comb begin
    state_next  = state;
    phase_next  = phase;
    dround_next = dround;
    unique case (state)
      ST_STREAM: begin
        if (cmd.capture) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next  = ST_ROUND;
        phase_next  = '0;
        dround_next = '0;
      end
      ST_ROUND: begin
        phase_next = phase + PHASE_W'(1);
        if (phase == '1) begin
          if (dround == DROUND_W'(DOUBLE_ROUNDS - 1)) begin
            state_next = ST_FEED;
          end else begin
            dround_next = dround + DROUND_W'(1);
          end
        end
      end
      ST_FEED: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_STREAM;
        end
      end
      default: begin
        state_next = ST_STREAM;
      end
    endcase
  end

  // Output valid flag follows writes and drains.
  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_STREAM;
      phase     <= '0;
      dround    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      dround    <= dround_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hw/rtl/s20sd_core.sv
// Datapath of the Salsa20 stream decrypt unit: state words, quarter-round unit,
// block counter, byte position and output register. Depends on s20sd_pkg.
module s20sd_core (
  input  logic                                clk,
  input  logic                                rst,
  input  s20sd_pkg::s20sd_cmd_t               cmd,
  input  s20sd_pkg::s20sd_cfg_t               cfg,
  input  logic [s20sd_pkg::BYTE_W-1:0]        in_byte,
  input  logic                                in_final,
  output logic [s20sd_pkg::BYTE_W-1:0]        out_byte,
  output logic                                out_final,
  output s20sd_pkg::s20sd_status_t            status
);
  import s20sd_pkg::*;

  logic [WORD_W-1:0] words [NUM_WORDS];
  logic [WORD_W-1:0] words_next [NUM_WORDS];
  logic [WORD_W-1:0] init [NUM_WORDS];
  logic [WORD_W-1:0] op_a [4];
  logic [WORD_W-1:0] op_b [4];
  logic [WORD_W-1:0] mix [4];
  logic [CTR_W-1:0]  counter, counter_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [BYTE_W-1:0] held_byte;
  logic              held_final;
  logic [BYTE_W-1:0] src_byte;
  logic              src_final;
  logic [CFG_DATA_W-1:0] hi_lo, hi_hi;

  assign status.pos_zero = (pos == '0);

  // Initial state words from the constants, key, nonce and block counter.
  always_comb begin
    hi_lo    = cfg.long_key_mode ? cfg.key_second_low  : cfg.key_first_low;
    hi_hi    = cfg.long_key_mode ? cfg.key_second_high : cfg.key_first_high;
    init[0]  = cfg.long_key_mode ? SIGMA32[0] : SIGMA16[0];
    init[1]  = cfg.key_first_low[31:0];
    init[2]  = cfg.key_first_low[63:32];
    init[3]  = cfg.key_first_high[31:0];
    init[4]  = cfg.key_first_high[63:32];
    init[5]  = cfg.long_key_mode ? SIGMA32[1] : SIGMA16[1];
    init[6]  = cfg.nonce_value[31:0];
    init[7]  = cfg.nonce_value[63:32];
    init[8]  = counter[31:0];
    init[9]  = counter[63:32];
    init[10] = cfg.long_key_mode ? SIGMA32[2] : SIGMA16[2];
    init[11] = hi_lo[31:0];
    init[12] = hi_lo[63:32];
    init[13] = hi_hi[31:0];
    init[14] = hi_hi[63:32];
    init[15] = cfg.long_key_mode ? SIGMA32[3] : SIGMA16[3];
  end

  // Operand selection: each phase reads fixed words of the four groups.
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      op_a[g] = '0;
      op_b[g] = '0;
      for (int p = 0; p < 8; p++) begin
        if (cmd.phase == PHASE_W'(p)) begin
          op_a[g] = words[QR_INDEX[p >> 2][g][p & 3]];
          op_b[g] = words[QR_INDEX[p >> 2][g][(p + 3) & 3]];
        end
      end
      mix[g] = rotl_step(op_a[g] + op_b[g], cmd.phase[1:0]);
    end
  end

  // State word update: load, round step, feed-forward, or byte shift on output.
  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      words_next[i] = words[i];
    end
    priority if (cmd.load) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_next[i] = init[i];
      end
    end else if (cmd.round_en) begin
      for (int p = 0; p < 8; p++) begin
        if (cmd.phase == PHASE_W'(p)) begin
          for (int g = 0; g < 4; g++) begin
            words_next[QR_INDEX[p >> 2][g][(p + 1) & 3]] =
              words[QR_INDEX[p >> 2][g][(p + 1) & 3]] ^ mix[g];
          end
        end
      end
    end else if (cmd.feed) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_next[i] = words[i] + init[i];
      end
    end else if (cmd.emit) begin
      // The current keystream byte always sits in the low byte of word zero.
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_next[i] = {words[(i + 1) % NUM_WORDS][7:0], words[i][31:8]};
      end
    end
  end

  // Source of the emitted byte: the held request or the one accepted now.
  assign src_byte  = cmd.emit_held ? held_byte  : in_byte;
  assign src_final = cmd.emit_held ? held_final : in_final;

  // Position advances on each result, the counter when the position wraps; a final byte rewinds both.
  always_comb begin
    pos_next     = pos;
    counter_next = counter;
    if (cmd.emit) begin
      if (src_final) begin
        pos_next     = '0;
        counter_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
        if (pos == '1) begin
          counter_next = counter + CTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      counter <= '0;
    end else begin
      pos     <= pos_next;
      counter <= counter_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      words[i] <= words_next[i];
    end
    if (cmd.capture) begin
      held_byte  <= in_byte;
      held_final <= in_final;
    end
    if (cmd.emit) begin
      out_byte  <= src_byte ^ words[0][7:0];
      out_final <= src_final;
    end
  end

endmodule

>>> tb/sv/salsa20_stream_checker.sv
`timescale 1ns / 1ps
// Checker for the Salsa20 stream decrypt unit: follows register writes, predicts every
// output byte from its own Salsa20/20 keystream and compares it with what comes out.
// Depends on s20sd_pkg for the register indexes and the port widths.
module salsa20_stream_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] cipher_byte
  input  logic                             s_tlast,   // final_byte
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [7:0]                       m_tdata,   // [7:0] plain_byte
  input  logic                             m_tlast,   // final_out
  input  logic                             cfg_we,
  input  logic [s20sd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [s20sd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatches,
  output int                               bytes_due
);
  import s20sd_pkg::*;

  // "expand 16-byte k" and "expand 32-byte k", four little-endian words each.
  localparam logic [31:0] EXPAND_16 [4] = '{
    32'h61707865, 32'h3120646e, 32'h79622d36, 32'h6b206574
  };
  localparam logic [31:0] EXPAND_32 [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  typedef struct packed {
    logic [7:0] plain;
    logic       last;
  } plain_byte_t;

  plain_byte_t plain_due [$];

  // Mirror of the register file and of the stream position.
  logic [63:0] key_a_lo, key_a_hi, key_b_lo, key_b_hi, nonce;
  logic        long_key;
  logic [63:0] blk_ctr;
  logic [5:0]  pos;
  logic [31:0] ks_words [16];
  logic [31:0] mix [16];

  function automatic logic [31:0] rot32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter(input int a, input int b, input int c, input int d);
    mix[b] ^= rot32(mix[a] + mix[d], 7);
    mix[c] ^= rot32(mix[b] + mix[a], 9);
    mix[d] ^= rot32(mix[c] + mix[b], 13);
    mix[a] ^= rot32(mix[d] + mix[c], 18);
  endfunction

  // Builds the 64-byte keystream block for the current counter and settings.
  function automatic void refill_keystream();
    logic [31:0] init [16];
    logic [31:0] sig [4];
    logic [63:0] tail_lo, tail_hi;
    if (long_key) begin
      sig = EXPAND_32;
      tail_lo = key_b_lo;
      tail_hi = key_b_hi;
    end else begin
      sig = EXPAND_16;
      tail_lo = key_a_lo;
      tail_hi = key_a_hi;
    end
    init[0]  = sig[0];
    init[1]  = key_a_lo[31:0];
    init[2]  = key_a_lo[63:32];
    init[3]  = key_a_hi[31:0];
    init[4]  = key_a_hi[63:32];
    init[5]  = sig[1];
    init[6]  = nonce[31:0];
    init[7]  = nonce[63:32];
    init[8]  = blk_ctr[31:0];
    init[9]  = blk_ctr[63:32];
    init[10] = sig[2];
    init[11] = tail_lo[31:0];
    init[12] = tail_lo[63:32];
    init[13] = tail_hi[31:0];
    init[14] = tail_hi[63:32];
    init[15] = sig[3];
    mix = init;
    for (int r = 0; r < 10; r++) begin
      quarter(0, 4, 8, 12);
      quarter(5, 9, 13, 1);
      quarter(10, 14, 2, 6);
      quarter(15, 3, 7, 11);
      quarter(0, 1, 2, 3);
      quarter(5, 6, 7, 4);
      quarter(10, 11, 8, 9);
      quarter(15, 12, 13, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + init[i];
  endfunction

  // Outputs are compared before inputs are predicted, so a result can never
  // be matched against a request taken at the same edge.
  always @(posedge clk) begin : track
    logic [31:0] ks;
    plain_byte_t due;
    if (rst) begin
      key_a_lo = '0;
      key_a_hi = '0;
      key_b_lo = '0;
      key_b_hi = '0;
      nonce = '0;
      long_key = 1'b0;
      blk_ctr = '0;
      pos = '0;
      mismatches = 0;
      plain_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_FIRST_LOW:   key_a_lo = cfg_data;
          REG_KEY_FIRST_HIGH:  key_a_hi = cfg_data;
          REG_KEY_SECOND_LOW:  key_b_lo = cfg_data;
          REG_KEY_SECOND_HIGH: key_b_hi = cfg_data;
          REG_LONG_KEY_MODE:   long_key = cfg_data[0];
          REG_NONCE_VALUE:     nonce = cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        if (plain_due.size() == 0) begin
          mismatches++;
          $display("%0t: output byte %h last %b with no request waiting",
                   $time, m_tdata, m_tlast);
        end else begin
          due = plain_due.pop_front();
          if (m_tdata !== due.plain) begin
            mismatches++;
            $display("%0t: plain byte expected %h actual %h", $time, due.plain, m_tdata);
          end
          if (m_tlast !== due.last) begin
            mismatches++;
            $display("%0t: last flag expected %b actual %b", $time, due.last, m_tlast);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        if (pos == 0) refill_keystream();
        ks = ks_words[pos[5:2]] >> (8 * pos[1:0]);
        plain_due.push_back('{plain: s_tdata ^ ks[7:0], last: s_tlast});
        pos = pos + 1'b1;
        if (pos == 0) blk_ctr = blk_ctr + 1'b1;
        // The end of a message restarts the keystream at block zero.
        if (s_tlast) begin
          blk_ctr = '0;
          pos = '0;
        end
      end
    end
    bytes_due = plain_due.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the Salsa20 stream decrypt testbench: clock, reset, stimulus and the verdict.
// Depends on s20sd_pkg, salsa20_stream_decrypt_unit and salsa20_stream_checker.
module tb_top;
  import s20sd_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 100;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_BYTES     = 100;
  localparam int PRESSURE_AFTER  = 200;
  localparam int PRESSURE_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int bytes_due;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  salsa20_stream_decrypt_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  salsa20_stream_checker plain_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .bytes_due  (bytes_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ends the run when neither side has moved a request for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall bursts, quiet stretches, and one long hold-off
  // while the sender keeps offering, so the unit backs up into its input.
  initial begin : receiver
    int stall_left;
    int quiet_left;
    int taken;
    bit pressed;
    stall_left = 0;
    quiet_left = 0;
    taken = 0;
    pressed = 1'b0;
    forever begin
      @(posedge clk);
      if (s_tvalid && s_tready) taken++;
      if (quiet_left > 0) quiet_left--;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!pressed && taken >= PRESSURE_AFTER) begin
        pressed = 1'b1;
        stall_left = PRESSURE_CYCLES;
      end else if (!calm && quiet_left == 0) begin
        case ($urandom_range(0, 15))
          0, 1:    stall_left = $urandom_range(1, 16);
          2:       quiet_left = $urandom_range(20, 100);
          default: ;
        endcase
      end
      m_tready <= (stall_left == 0) && !rst;
    end
  end

  // Offers one byte, at times after a random gap, and returns at the edge
  // where the unit takes it.
  task automatic send_byte(input logic [7:0] data, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_message(input int len, input bit close);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
  endtask

  // Stops offering and waits until every predicted byte has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    @(posedge clk);
  endtask

  // Drives one register write; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    int left;
    int len;
    bit close;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Zero key and nonce after reset in 16-byte mode: a single-byte message,
    // then a short one with the data extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain();

    // All-ones key and nonce in 32-byte mode; only bit 0 of the mode counts.
    write_reg(REG_KEY_FIRST_LOW, '1);
    write_reg(REG_KEY_FIRST_HIGH, '1);
    write_reg(REG_KEY_SECOND_LOW, '1);
    write_reg(REG_KEY_SECOND_HIGH, '1);
    write_reg(REG_LONG_KEY_MODE, '1);
    write_reg(REG_NONCE_VALUE, '1);
    cfg_we <= 1'b0;
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    drain();

    // A mode change in the middle of a block must not touch the current block,
    // the counter or the position.
    write_reg(REG_LONG_KEY_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    cfg_we <= 1'b0;
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Random phases: new settings, then messages of mixed length; a phase may
    // leave its last message open so the next writes land mid-message.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_FIRST_LOW, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_FIRST_HIGH, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_SECOND_LOW, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_SECOND_HIGH, pick_value());
      write_reg(REG_LONG_KEY_MODE, {$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) write_reg(REG_NONCE_VALUE, pick_value());
      cfg_we <= 1'b0;
      left = PHASE_BYTES;
      while (left > 0) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, 3);
          1, 2:    len = $urandom_range(64, 140);
          default: len = $urandom_range(1, 70);
        endcase
        if (len > left) len = left;
        left -= len;
        close = (left > 0) || ($urandom_range(0, 2) != 0);
        send_message(len, close);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && bytes_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
